FILE: src/ffba_pkg.sv
// First-fit block allocator: shared package.
// Holds the transfer payload types and the operation, status and register codes.
// No dependencies.
package ffba_pkg;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_BAD_ALIGN = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 2'd1;

  // Configuration reset values
  localparam logic [31:0] BLOCK_SIZE_RST   = 32'd256;
  localparam logic [10:0] TOTAL_BLOCKS_RST = 11'd1024;

  typedef struct packed {
    logic        operation;
    logic [31:0] size_bytes;
    logic [31:0] align_bytes;
    logic [31:0] handle_in;
  } ffba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [31:0] offset;
  } ffba_out_t;

endpackage

FILE: src/first_fit_block_allocator_top.sv
// First-fit block allocator, top level: sequencer, node and handle tables.
// Depends on ffba_pkg, ffba_ram and ffba_div.
//
// Usage
//   Input channel: present an item on in_data and raise start; the transfer
//   happens at a rising edge with start high and busy low. busy then stays
//   high until the result has been issued.
//   Result channel: out_valid is high for exactly one cycle with out_data;
//   the receiver cannot stall it, so sample it on that cycle.
//   Configuration: cfg_we with cfg_index/cfg_wdata writes block_size (0) or
//   total_blocks (1); either write rebuilds the pool as one free region.
//   Sequencing: each item is handled by one sequencer sharing a bit-serial
//   divider and the node/handle RAMs (one read a cycle).
//   Allocate: check the alignment and round the size up on the divider,
//   walk the free regions, divide once more per region tested when the
//   alignment exceeds the block size, and split off the padding if needed.
//   Free: scan the handle entries, walk the free regions below the freed
//   range, then end the walk, merge and compact.
//   Reset: busy for one cycle while node zero is written to span the pool;
//   the same single cycle follows every configuration write.
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int MAX_HANDLES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ffba_pkg::ffba_in_t                 in_data,
  output logic                               out_valid,
  output ffba_pkg::ffba_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_wdata
);
  import ffba_pkg::*;

  localparam int NW  = $clog2(MAX_BLOCKS);
  localparam int BW  = $clog2(MAX_BLOCKS + 1);
  localparam int HW  = $clog2(MAX_HANDLES);
  localparam int HCW = $clog2(MAX_HANDLES + 1);

  // Sequencer states
  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_ACHK0  = 5'd2;
  localparam logic [4:0] S_ACHK   = 5'd3;
  localparam logic [4:0] S_AREQ   = 5'd4;
  localparam logic [4:0] S_WTOP   = 5'd5;
  localparam logic [4:0] S_WDAT   = 5'd6;
  localparam logic [4:0] S_WPAD   = 5'd7;
  localparam logic [4:0] S_SPOP   = 5'd8;
  localparam logic [4:0] S_SPLW1  = 5'd9;
  localparam logic [4:0] S_SPLW2  = 5'd10;
  localparam logic [4:0] S_AOK    = 5'd11;
  localparam logic [4:0] S_FHRD   = 5'd12;
  localparam logic [4:0] S_FHDAT  = 5'd13;
  localparam logic [4:0] S_FWTOP  = 5'd14;
  localparam logic [4:0] S_FWDAT  = 5'd15;
  localparam logic [4:0] S_FMERGE = 5'd16;
  localparam logic [4:0] S_FPOP   = 5'd17;
  localparam logic [4:0] S_FNEW1  = 5'd18;
  localparam logic [4:0] S_FNEW2  = 5'd19;
  localparam logic [4:0] S_FCPRD  = 5'd20;
  localparam logic [4:0] S_FCPWR  = 5'd21;

  logic [4:0]     state_r, state_nxt;
  logic [31:0]    blk_size_r, blk_size_nxt;
  logic [10:0]    tot_blocks_r, tot_blocks_nxt;
  ffba_in_t       in_r, in_nxt;
  logic           out_valid_r, out_valid_nxt;
  ffba_out_t      out_r, out_nxt;
  logic [NW-1:0]  free_head_r, free_head_nxt;
  logic [BW-1:0]  free_count_r, free_count_nxt;
  logic [BW-1:0]  spare_top_r, spare_top_nxt;
  logic [BW-1:0]  next_unused_r, next_unused_nxt;
  logic [HCW-1:0] fill_r, fill_nxt;
  logic [31:0]    next_id_r, next_id_nxt;
  logic [31:0]    k_r, k_nxt;
  logic [32:0]    req_r, req_nxt;
  logic [NW-1:0]  cur_r, cur_nxt;
  logic [NW-1:0]  prev_r, prev_nxt;
  logic           has_prev_r, has_prev_nxt;
  logic           has_cur_r, has_cur_nxt;
  logic [BW-1:0]  i_r, i_nxt;
  logic [BW-1:0]  st_r, st_nxt;
  logic [BW-1:0]  len_r, len_nxt;
  logic [NW-1:0]  nxt_r, nxt_nxt;
  logic [BW-1:0]  pad_r, pad_nxt;
  logic [BW-1:0]  pst_r, pst_nxt;
  logic [BW-1:0]  plen_r, plen_nxt;
  logic [BW-1:0]  hst_r, hst_nxt;
  logic [BW-1:0]  hln_r, hln_nxt;
  logic [HCW-1:0] j_r, j_nxt;
  logic [NW-1:0]  nn_r, nn_nxt;
  logic           div_go_r, div_go_nxt;
  logic [32:0]    div_a_r, div_a_nxt;
  logic [31:0]    div_b_r, div_b_nxt;

  // RAM ports
  logic           ns_we, nl_we, nx_we, sp_we, hi_we, hs_we, hl_we;
  logic [NW-1:0]  ns_wa, nl_wa, nx_wa, sp_wa, node_ra;
  logic [BW-1:0]  ns_wd, nl_wd;
  logic [NW-1:0]  nx_wd, sp_wd;
  logic [HW-1:0]  h_wa, h_ra;
  logic [31:0]    hi_wd;
  logic [BW-1:0]  hs_wd, hl_wd;
  logic [BW-1:0]  rd_start, rd_len, h_st_q, h_len_q;
  logic [NW-1:0]  rd_next, sp_q;
  logic [31:0]    h_id_q;

  logic           div_done;
  logic [32:0]    div_q;
  logic [31:0]    div_r;

  logic [31:0]    bs_eff;
  logic [BW-1:0]  eff_blocks;
  logic           bs_ge_align;
  logic           node_avail;
  logic [BW-1:0]  top_m1;
  logic [HCW-1:0] fill_m1;
  logic [31:0]    pad_w;
  logic [31:0]    off_w;
  logic [31:0]    id_inc;
  logic [BW:0]    prev_end, hnd_end;
  logic           with_prev, with_next;

  assign bs_eff      = (blk_size_r == 32'd0) ? 32'd1 : blk_size_r;
  assign bs_ge_align = bs_eff >= in_r.align_bytes;
  assign node_avail  = (spare_top_r != '0) || (next_unused_r < BW'(MAX_BLOCKS));
  assign top_m1      = spare_top_r - 1'b1;
  assign fill_m1     = fill_r - 1'b1;
  assign pad_w       = (div_r == 32'd0) ? 32'd0 : (k_r - div_r);
  assign off_w       = 32'(st_r) * bs_eff;
  assign id_inc      = next_id_r + 32'd1;
  assign prev_end    = {1'b0, pst_r} + {1'b0, plen_r};
  assign hnd_end     = {1'b0, hst_r} + {1'b0, hln_r};
  assign with_prev   = has_prev_r && (prev_end == {1'b0, hst_r});
  assign with_next   = has_cur_r && (hnd_end == {1'b0, st_r});

  always_comb begin
    if (tot_blocks_r == 11'd0) begin
      eff_blocks = BW'(1);
    end else if (32'(tot_blocks_r) > 32'(MAX_BLOCKS)) begin
      eff_blocks = BW'(MAX_BLOCKS);
    end else begin
      eff_blocks = BW'(tot_blocks_r);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    blk_size_nxt    = blk_size_r;
    tot_blocks_nxt  = tot_blocks_r;
    in_nxt          = in_r;
    out_valid_nxt   = 1'b0;
    out_nxt         = out_r;
    free_head_nxt   = free_head_r;
    free_count_nxt  = free_count_r;
    spare_top_nxt   = spare_top_r;
    next_unused_nxt = next_unused_r;
    fill_nxt        = fill_r;
    next_id_nxt     = next_id_r;
    k_nxt           = k_r;
    req_nxt         = req_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    has_prev_nxt    = has_prev_r;
    has_cur_nxt     = has_cur_r;
    i_nxt           = i_r;
    st_nxt          = st_r;
    len_nxt         = len_r;
    nxt_nxt         = nxt_r;
    pad_nxt         = pad_r;
    pst_nxt         = pst_r;
    plen_nxt        = plen_r;
    hst_nxt         = hst_r;
    hln_nxt         = hln_r;
    j_nxt           = j_r;
    nn_nxt          = nn_r;
    div_go_nxt      = 1'b0;
    div_a_nxt       = div_a_r;
    div_b_nxt       = div_b_r;
    ns_we = 1'b0; ns_wa = cur_r; ns_wd = '0;
    nl_we = 1'b0; nl_wa = cur_r; nl_wd = '0;
    nx_we = 1'b0; nx_wa = cur_r; nx_wd = '0;
    sp_we = 1'b0; sp_wa = spare_top_r[NW-1:0]; sp_wd = cur_r;
    hi_we = 1'b0; hs_we = 1'b0; hl_we = 1'b0;
    h_wa  = fill_r[HW-1:0];
    hi_wd = next_id_r; hs_wd = st_r; hl_wd = req_r[BW-1:0];
    node_ra = cur_r;
    h_ra    = j_r[HW-1:0];

    case (state_r)
      S_INIT: begin
        // rebuild the pool as one region in node zero
        ns_we = 1'b1; ns_wa = '0; ns_wd = '0;
        nl_we = 1'b1; nl_wa = '0; nl_wd = eff_blocks;
        nx_we = 1'b1; nx_wa = '0; nx_wd = '0;
        free_head_nxt   = '0;
        free_count_nxt  = BW'(1);
        spare_top_nxt   = '0;
        next_unused_nxt = BW'(1);
        fill_nxt        = '0;
        next_id_nxt     = 32'd1;
        state_nxt       = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          in_nxt = in_data;
          j_nxt  = '0;
          state_nxt = (in_data.operation == OP_ALLOC) ? S_ACHK0 : S_FHRD;
        end
      end
      S_ACHK0: begin
        if (in_r.align_bytes == 32'd0) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_BAD_ALIGN, handle_out: 32'd0, offset: 32'd0};
          state_nxt = S_IDLE;
        end else begin
          div_go_nxt = 1'b1;
          if (bs_ge_align) begin
            div_a_nxt = {1'b0, bs_eff};
            div_b_nxt = in_r.align_bytes;
          end else begin
            div_a_nxt = {1'b0, in_r.align_bytes};
            div_b_nxt = bs_eff;
          end
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (div_done) begin
          if (div_r != 32'd0) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{status: ST_BAD_ALIGN, handle_out: 32'd0, offset: 32'd0};
            state_nxt = S_IDLE;
          end else begin
            k_nxt = bs_ge_align ? 32'd0 : div_q[31:0];
            if (in_r.size_bytes == 32'd0 || fill_r >= HCW'(MAX_HANDLES)) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{status: ST_NO_FIT, handle_out: 32'd0, offset: 32'd0};
              state_nxt = S_IDLE;
            end else begin
              // round the size up to whole blocks
              div_go_nxt = 1'b1;
              div_a_nxt  = {1'b0, in_r.size_bytes} + {1'b0, bs_eff} - 33'd1;
              div_b_nxt  = bs_eff;
              state_nxt  = S_AREQ;
            end
          end
        end
      end
      S_AREQ: begin
        if (div_done) begin
          req_nxt      = div_q;
          cur_nxt      = free_head_r;
          has_prev_nxt = 1'b0;
          i_nxt        = '0;
          state_nxt    = S_WTOP;
        end
      end
      S_WTOP: begin
        if (i_r >= free_count_r) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_NO_FIT, handle_out: 32'd0, offset: 32'd0};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WDAT;
        end
      end
      S_WDAT: begin
        st_nxt  = rd_start;
        len_nxt = rd_len;
        nxt_nxt = rd_next;
        if (33'(rd_len) >= req_r && k_r > 32'd1) begin
          div_go_nxt = 1'b1;
          div_a_nxt  = 33'(rd_start);
          div_b_nxt  = k_r;
          state_nxt  = S_WPAD;
        end else if (33'(rd_len) >= req_r) begin
          state_nxt = S_AOK;
        end else begin
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
          cur_nxt      = rd_next;
          i_nxt        = i_r + 1'b1;
          state_nxt    = S_WTOP;
        end
      end
      S_WPAD: begin
        if (div_done) begin
          if (pad_w == 32'd0) begin
            state_nxt = S_AOK;
          end else if (pad_w < 32'(len_r) &&
                       (33'(len_r) - 33'(pad_w)) >= req_r) begin
            if (!node_avail) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{status: ST_NO_FIT, handle_out: 32'd0, offset: 32'd0};
              state_nxt = S_IDLE;
            end else begin
              pad_nxt = pad_w[BW-1:0];
              if (spare_top_r != '0) begin
                spare_top_nxt = top_m1;
                state_nxt     = S_SPOP;
              end else begin
                nn_nxt          = next_unused_r[NW-1:0];
                next_unused_nxt = next_unused_r + 1'b1;
                state_nxt       = S_SPLW1;
              end
            end
          end else begin
            // padding leaves too little: skip this region
            prev_nxt     = cur_r;
            has_prev_nxt = 1'b1;
            cur_nxt      = nxt_r;
            i_nxt        = i_r + 1'b1;
            state_nxt    = S_WTOP;
          end
        end
      end
      S_SPOP: begin
        nn_nxt    = sp_q;
        state_nxt = S_SPLW1;
      end
      S_SPLW1: begin
        // aligned tail becomes a region of its own
        ns_we = 1'b1; ns_wa = nn_r; ns_wd = st_r + pad_r;
        nl_we = 1'b1; nl_wa = nn_r; nl_wd = len_r - pad_r;
        nx_we = 1'b1; nx_wa = nn_r; nx_wd = nxt_r;
        state_nxt = S_SPLW2;
      end
      S_SPLW2: begin
        nx_we = 1'b1; nx_wa = cur_r; nx_wd = nn_r;
        nl_we = 1'b1; nl_wa = cur_r; nl_wd = pad_r;
        free_count_nxt = free_count_r + 1'b1;
        prev_nxt       = cur_r;
        has_prev_nxt   = 1'b1;
        cur_nxt        = nn_r;
        st_nxt         = st_r + pad_r;
        len_nxt        = len_r - pad_r;
        state_nxt      = S_AOK;
      end
      S_AOK: begin
        hi_we = 1'b1; hs_we = 1'b1; hl_we = 1'b1;
        fill_nxt    = fill_r + 1'b1;
        next_id_nxt = (id_inc == 32'd0) ? 32'd1 : id_inc;
        if (33'(len_r) > req_r) begin
          ns_we = 1'b1; ns_wd = st_r + req_r[BW-1:0];
          nl_we = 1'b1; nl_wd = len_r - req_r[BW-1:0];
        end else begin
          // region used up: unlink and return its node
          if (has_prev_r) begin
            nx_we = 1'b1; nx_wa = prev_r; nx_wd = nxt_r;
          end else begin
            free_head_nxt = nxt_r;
          end
          free_count_nxt = free_count_r - 1'b1;
          if (spare_top_r < BW'(MAX_BLOCKS)) begin
            sp_we         = 1'b1;
            spare_top_nxt = spare_top_r + 1'b1;
          end
        end
        out_valid_nxt = 1'b1;
        out_nxt = '{status: ST_OK, handle_out: next_id_r, offset: off_w};
        state_nxt = S_IDLE;
      end
      S_FHRD: begin
        if (j_r >= fill_r) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_UNKNOWN, handle_out: 32'd0, offset: 32'd0};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FHDAT;
        end
      end
      S_FHDAT: begin
        if (h_id_q == in_r.handle_in) begin
          hst_nxt      = h_st_q;
          hln_nxt      = h_len_q;
          cur_nxt      = free_head_r;
          i_nxt        = '0;
          has_prev_nxt = 1'b0;
          has_cur_nxt  = 1'b0;
          state_nxt    = S_FWTOP;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_FHRD;
        end
      end
      S_FWTOP: begin
        if (i_r >= free_count_r) begin
          has_cur_nxt = 1'b0;
          state_nxt   = S_FMERGE;
        end else begin
          state_nxt = S_FWDAT;
        end
      end
      S_FWDAT: begin
        if (rd_start > hst_r) begin
          has_cur_nxt = 1'b1;
          st_nxt      = rd_start;
          len_nxt     = rd_len;
          nxt_nxt     = rd_next;
          state_nxt   = S_FMERGE;
        end else begin
          pst_nxt      = rd_start;
          plen_nxt     = rd_len;
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
          cur_nxt      = rd_next;
          i_nxt        = i_r + 1'b1;
          state_nxt    = S_FWTOP;
        end
      end
      S_FMERGE: begin
        if (with_prev && with_next) begin
          nl_we = 1'b1; nl_wa = prev_r; nl_wd = plen_r + hln_r + len_r;
          nx_we = 1'b1; nx_wa = prev_r; nx_wd = nxt_r;
          if (spare_top_r < BW'(MAX_BLOCKS)) begin
            sp_we         = 1'b1;
            spare_top_nxt = spare_top_r + 1'b1;
          end
          free_count_nxt = free_count_r - 1'b1;
          state_nxt      = S_FCPRD;
        end else if (with_prev) begin
          nl_we = 1'b1; nl_wa = prev_r; nl_wd = plen_r + hln_r;
          state_nxt = S_FCPRD;
        end else if (with_next) begin
          ns_we = 1'b1; ns_wd = hst_r;
          nl_we = 1'b1; nl_wd = len_r + hln_r;
          state_nxt = S_FCPRD;
        end else if (!node_avail) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_NO_FIT, handle_out: 32'd0, offset: 32'd0};
          state_nxt = S_IDLE;
        end else if (spare_top_r != '0) begin
          spare_top_nxt = top_m1;
          state_nxt     = S_FPOP;
        end else begin
          nn_nxt          = next_unused_r[NW-1:0];
          next_unused_nxt = next_unused_r + 1'b1;
          state_nxt       = S_FNEW1;
        end
      end
      S_FPOP: begin
        nn_nxt    = sp_q;
        state_nxt = S_FNEW1;
      end
      S_FNEW1: begin
        ns_we = 1'b1; ns_wa = nn_r; ns_wd = hst_r;
        nl_we = 1'b1; nl_wa = nn_r; nl_wd = hln_r;
        nx_we = 1'b1; nx_wa = nn_r; nx_wd = has_cur_r ? cur_r : '0;
        if (has_prev_r) begin
          state_nxt = S_FNEW2;
        end else begin
          free_head_nxt  = nn_r;
          free_count_nxt = free_count_r + 1'b1;
          state_nxt      = S_FCPRD;
        end
      end
      S_FNEW2: begin
        nx_we = 1'b1; nx_wa = prev_r; nx_wd = nn_r;
        free_count_nxt = free_count_r + 1'b1;
        state_nxt      = S_FCPRD;
      end
      S_FCPRD: begin
        // fetch the last entry to close the gap
        h_ra      = fill_m1[HW-1:0];
        fill_nxt  = fill_m1;
        state_nxt = S_FCPWR;
      end
      S_FCPWR: begin
        hi_we = 1'b1; hs_we = 1'b1; hl_we = 1'b1;
        h_wa  = j_r[HW-1:0];
        hi_wd = h_id_q; hs_wd = h_st_q; hl_wd = h_len_q;
        out_valid_nxt = 1'b1;
        out_nxt = '{status: ST_OK, handle_out: 32'd0, offset: 32'd0};
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // a write to either register rebuilds the pool
    if (cfg_we && cfg_index == CFG_BLOCK_SIZE) begin
      blk_size_nxt = cfg_wdata;
      state_nxt    = S_INIT;
    end else if (cfg_we && cfg_index == CFG_TOTAL_BLOCKS) begin
      tot_blocks_nxt = cfg_wdata[10:0];
      state_nxt      = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      blk_size_r    <= BLOCK_SIZE_RST;
      tot_blocks_r  <= TOTAL_BLOCKS_RST;
      out_valid_r   <= 1'b0;
      free_head_r   <= '0;
      free_count_r  <= BW'(1);
      spare_top_r   <= '0;
      next_unused_r <= BW'(1);
      fill_r        <= '0;
      next_id_r     <= 32'd1;
      div_go_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      blk_size_r    <= blk_size_nxt;
      tot_blocks_r  <= tot_blocks_nxt;
      out_valid_r   <= out_valid_nxt;
      free_head_r   <= free_head_nxt;
      free_count_r  <= free_count_nxt;
      spare_top_r   <= spare_top_nxt;
      next_unused_r <= next_unused_nxt;
      fill_r        <= fill_nxt;
      next_id_r     <= next_id_nxt;
      div_go_r      <= div_go_nxt;
    end
    in_r       <= in_nxt;
    out_r      <= out_nxt;
    k_r        <= k_nxt;
    req_r      <= req_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    has_prev_r <= has_prev_nxt;
    has_cur_r  <= has_cur_nxt;
    i_r        <= i_nxt;
    st_r       <= st_nxt;
    len_r      <= len_nxt;
    nxt_r      <= nxt_nxt;
    pad_r      <= pad_nxt;
    pst_r      <= pst_nxt;
    plen_r     <= plen_nxt;
    hst_r      <= hst_nxt;
    hln_r      <= hln_nxt;
    j_r        <= j_nxt;
    nn_r       <= nn_nxt;
    div_a_r    <= div_a_nxt;
    div_b_r    <= div_b_nxt;
  end

  // Node table
  ffba_ram #(.WIDTH(BW), .DEPTH(MAX_BLOCKS)) u_node_start (
    .clk(clk), .we(ns_we), .waddr(ns_wa), .wdata(ns_wd), .raddr(node_ra), .rdata(rd_start)
  );
  ffba_ram #(.WIDTH(BW), .DEPTH(MAX_BLOCKS)) u_node_length (
    .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(node_ra), .rdata(rd_len)
  );
  ffba_ram #(.WIDTH(NW), .DEPTH(MAX_BLOCKS)) u_node_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(node_ra), .rdata(rd_next)
  );
  ffba_ram #(.WIDTH(NW), .DEPTH(MAX_BLOCKS)) u_spare_stack (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(top_m1[NW-1:0]), .rdata(sp_q)
  );

  // Handle table
  ffba_ram #(.WIDTH(32), .DEPTH(MAX_HANDLES)) u_handle_ids (
    .clk(clk), .we(hi_we), .waddr(h_wa), .wdata(hi_wd), .raddr(h_ra), .rdata(h_id_q)
  );
  ffba_ram #(.WIDTH(BW), .DEPTH(MAX_HANDLES)) u_handle_starts (
    .clk(clk), .we(hs_we), .waddr(h_wa), .wdata(hs_wd), .raddr(h_ra), .rdata(h_st_q)
  );
  ffba_ram #(.WIDTH(BW), .DEPTH(MAX_HANDLES)) u_handle_lengths (
    .clk(clk), .we(hl_we), .waddr(h_wa), .wdata(hl_wd), .raddr(h_ra), .rdata(h_len_q)
  );

  // Shared divider: alignment check, size rounding, padding remainder
  ffba_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go_r), .dividend(div_a_r), .divisor(div_b_r),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held");

  // Failed requests carry no handle and no offset
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |-> (out_r.handle_out == 32'd0 &&
    out_r.offset == 32'd0)) else $error("failure with payload");

  // Table counts stay within their stores
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= HCW'(MAX_HANDLES)) && (spare_top_r <= BW'(MAX_BLOCKS)))
    else $error("table count overrun");

  // The divider is only started from the idle-free sequencer, never on an accept
  a_no_div_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !div_go_r) else $error("divider started on transfer");

endmodule

FILE: src/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ffba_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module ffba_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [32:0] quotient,
  output logic [31:0] remainder
);

  logic [32:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;

  assign shifted = {rem_r, quo_r[32]};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = 6'd33;
    end else if (cnt_r != 6'd0) begin
      // shift in one dividend bit, subtract where it fits
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = 32'(shifted - {1'b0, dsr_r});
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: tb/ffba_checker.sv
// Scoreboard for the first-fit block allocator: watches the command, result and register ports.
// Predicts each result with its own copy of the pool and compares it field by field.
// Depends on ffba_pkg.
module ffba_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  ffba_pkg::ffba_in_t             in_data,
  input  logic                           out_valid,
  input  ffba_pkg::ffba_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int NODES = 1024;
  localparam int HANDLES = 1024;

  logic [31:0] blk_size;
  logic [10:0] pool_blocks;

  int unsigned nxt [NODES];
  int unsigned nst [NODES];
  int unsigned nlen [NODES];
  int unsigned spare [NODES];
  int unsigned head, region_cnt, spare_top, fresh_node;
  int unsigned hid [HANDLES];
  int unsigned hst [HANDLES];
  int unsigned hlen [HANDLES];
  int unsigned hfill, next_id;

  ffba_out_t expected_results[$];

  function automatic int unsigned eff_bs();
    return (blk_size == 0) ? 1 : blk_size;
  endfunction

  function automatic void rebuild_pool();
    int unsigned nb;
    nb = (pool_blocks == 0) ? 1 : (pool_blocks > NODES) ? NODES : pool_blocks;
    for (int i = 0; i < NODES; i++) begin
      nxt[i] = 0; nst[i] = 0; nlen[i] = 0; spare[i] = 0;
    end
    for (int i = 0; i < HANDLES; i++) begin
      hid[i] = 0; hst[i] = 0; hlen[i] = 0;
    end
    head = 0; nlen[0] = nb; region_cnt = 1;
    spare_top = 0; fresh_node = 1; hfill = 0; next_id = 1;
  endfunction

  function automatic bit node_free_left();
    return spare_top > 0 || fresh_node < NODES;
  endfunction

  function automatic int unsigned take_node();
    if (spare_top > 0) begin
      spare_top--;
      return spare[spare_top] % NODES;
    end
    fresh_node++;
    return (fresh_node - 1) % NODES;
  endfunction

  function automatic void give_node(int unsigned idx);
    if (spare_top < NODES) begin
      spare[spare_top] = idx % NODES;
      spare_top++;
    end
  endfunction

  function automatic ffba_out_t allocate(logic [31:0] size, logic [31:0] align);
    ffba_out_t r;
    longint unsigned bs, k, req, len, st, aligned, pad;
    int unsigned prev, cur, nn, id;
    bit has_prev, ok;
    r = '0;
    bs = eff_bs(); k = 0; prev = 0; has_prev = 0; cur = head % NODES;
    if (align == 0) begin r.status = ST_BAD_ALIGN; return r; end
    if (bs >= align) begin
      if (bs % align != 0) begin r.status = ST_BAD_ALIGN; return r; end
    end else begin
      if (align % bs != 0) begin r.status = ST_BAD_ALIGN; return r; end
      k = align / bs;
    end
    if (size == 0 || hfill >= HANDLES) begin r.status = ST_NO_FIT; return r; end
    req = (longint'(size) + bs - 1) / bs;
    for (int unsigned i = 0; i < region_cnt; i++) begin
      len = nlen[cur]; st = nst[cur];
      ok = len >= req;
      if (ok && k > 0) begin
        aligned = ((st + k - 1) / k) * k;
        pad = aligned - st;
        if (pad > 0) begin
          if (pad < len && len - pad >= req) begin
            if (!node_free_left()) begin r.status = ST_NO_FIT; return r; end
            // split off the padding as a region of its own
            nn = take_node();
            nst[nn] = aligned; nlen[nn] = len - pad;
            nxt[nn] = nxt[cur]; nxt[cur] = nn; nlen[cur] = pad;
            region_cnt++;
            prev = cur; has_prev = 1; cur = nn; i++;
          end else begin
            ok = 0;
          end
        end
      end
      if (ok) begin
        id = next_id;
        next_id++;
        if (next_id == 0) next_id = 1;
        hid[hfill] = id; hst[hfill] = nst[cur]; hlen[hfill] = req;
        hfill++;
        r.status = ST_OK; r.handle_out = id;
        r.offset = 32'(longint'(nst[cur]) * bs);
        if (nlen[cur] > req) begin
          nst[cur] += req; nlen[cur] -= req;
        end else begin
          if (has_prev) nxt[prev] = nxt[cur];
          else head = nxt[cur];
          region_cnt--;
          give_node(cur);
        end
        return r;
      end
      prev = cur; has_prev = 1; cur = nxt[cur] % NODES;
    end
    r.status = ST_NO_FIT;
    return r;
  endfunction

  function automatic ffba_out_t release_handle(logic [31:0] h);
    ffba_out_t r;
    int unsigned j, st, ln, i, prev, cur, nn;
    bit has_prev, has_cur, w_prev, w_next;
    r = '0; prev = 0; cur = head % NODES; has_prev = 0;
    for (j = 0; j < hfill; j++) if (hid[j] == h) break;
    if (j >= hfill) begin r.status = ST_UNKNOWN; return r; end
    st = hst[j]; ln = hlen[j];
    for (i = 0; i < region_cnt; i++) begin
      if (nst[cur] > st) break;
      prev = cur; has_prev = 1; cur = nxt[cur] % NODES;
    end
    has_cur = i < region_cnt;
    w_prev = has_prev && nst[prev] + nlen[prev] == st;
    w_next = has_cur && st + ln == nst[cur];
    if (w_prev && w_next) begin
      nlen[prev] += ln + nlen[cur]; nxt[prev] = nxt[cur];
      give_node(cur); region_cnt--;
    end else if (w_prev) begin
      nlen[prev] += ln;
    end else if (w_next) begin
      nst[cur] = st; nlen[cur] += ln;
    end else begin
      if (!node_free_left()) begin r.status = ST_NO_FIT; return r; end
      nn = take_node();
      nst[nn] = st; nlen[nn] = ln; nxt[nn] = has_cur ? cur : 0;
      if (has_prev) nxt[prev] = nn;
      else head = nn;
      region_cnt++;
    end
    // compact the handle table by moving the last entry into the hole
    hfill--;
    hid[j] = hid[hfill]; hst[j] = hst[hfill]; hlen[j] = hlen[hfill];
    r.status = ST_OK;
    return r;
  endfunction

  assign pending = expected_results.size();

  initial errors = 0;

  always @(posedge clk) begin
    ffba_out_t exp_r;
    if (!rst_n) begin
      blk_size = BLOCK_SIZE_RST;
      pool_blocks = TOTAL_BLOCKS_RST;
      rebuild_pool();
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.status !== exp_r.status)
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_r.status, out_data.status);
          if (out_data.handle_out !== exp_r.handle_out)
            $display("%0t: handle mismatch: expected %0h, actual %0h",
                     $time, exp_r.handle_out, out_data.handle_out);
          if (out_data.offset !== exp_r.offset)
            $display("%0t: offset mismatch: expected %0h, actual %0h",
                     $time, exp_r.offset, out_data.offset);
          if (out_data !== exp_r) errors++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_BLOCK_SIZE) begin
          blk_size = cfg_wdata; rebuild_pool();
        end else if (cfg_index == CFG_TOTAL_BLOCKS) begin
          pool_blocks = cfg_wdata[10:0]; rebuild_pool();
        end
      end
      if (start && !busy) begin
        if (in_data.operation == OP_ALLOC)
          expected_results.push_back(allocate(in_data.size_bytes, in_data.align_bytes));
        else
          expected_results.push_back(release_handle(in_data.handle_in));
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the allocator testbench: clock, reset, stimulus and the verdict.
// Depends on ffba_pkg, first_fit_block_allocator_top and ffba_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ffba_in_t in_data = '0;
  logic out_valid;
  ffba_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BLOCK_SIZE;
  logic [31:0] cfg_wdata = '0;
  int errors, pending;

  // handles the allocator has issued and the stimulus has not yet released
  logic [31:0] live_handles[$];
  logic [31:0] cur_bs;
  int idle_pct;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  first_fit_block_allocator_top dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  ffba_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  // record every handle that comes back, so frees can aim at live ones
  always @(posedge clk)
    if (rst_n && out_valid && out_data.status == ST_OK && out_data.handle_out != 0)
      live_handles.push_back(out_data.handle_out);

  // Hold start high until the transfer, then drop it or keep it for the next
  // item; a random gap follows at the current idling rate.
  task automatic transfer(ffba_in_t item);
    in_data <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic go_quiet();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drain the block, then write one register; the pool rebuilds itself.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    go_quiet();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_BLOCK_SIZE) cur_bs = val;
    live_handles.delete();
  endtask

  function automatic ffba_in_t mk_alloc(logic [31:0] size, logic [31:0] align);
    ffba_in_t it;
    it = '0;
    it.operation = OP_ALLOC;
    it.size_bytes = size;
    it.align_bytes = align;
    it.handle_in = $urandom;
    return it;
  endfunction

  function automatic ffba_in_t mk_free(logic [31:0] h);
    ffba_in_t it;
    it.operation = OP_FREE;
    it.size_bytes = $urandom;
    it.align_bytes = $urandom;
    it.handle_in = h;
    return it;
  endfunction

  // Mostly well-formed requests against the live set, some noise besides.
  function automatic ffba_in_t random_item();
    longint unsigned bs, sz, al;
    int idx;
    int unsigned pick;
    bs = (cur_bs == 0) ? 1 : cur_bs;
    pick = $urandom_range(99);
    if (pick < ((live_handles.size() > 40) ? 70 : 35)) begin
      if (live_handles.size() > 0 && $urandom_range(99) < 85) begin
        idx = $urandom_range(live_handles.size() - 1);
        pick = live_handles[idx];
        live_handles.delete(idx);
        return mk_free(pick);
      end
      return mk_free(($urandom_range(1)) ? $urandom : $urandom_range(1, 80));
    end
    pick = $urandom_range(99);
    if (pick < 82) begin
      sz = longint'($urandom_range(1, 8)) * bs - $urandom_range(0, 32'(bs - 1));
      if (sz == 0 || sz > 64'hFFFF_FFFF) sz = $urandom_range(1, 32'hFFFF_FFFF);
    end else if (pick < 95) begin
      sz = $urandom;
    end else begin
      sz = 0;
    end
    pick = $urandom_range(99);
    if (pick < 55) al = bs;
    else if (pick < 80) al = bs << $urandom_range(1, 3);
    else if (pick < 90) al = bs >> $urandom_range(0, 4);
    else al = $urandom;
    if (al == 0 || al > 64'h8000_0000) al = bs;
    if ($urandom_range(199) == 0) al = 0;
    return mk_alloc(32'(sz), 32'(al));
  endfunction

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [31:0] bs_list[6];
    logic [31:0] tb_list[6];
    bs_list = '{32'd256, 32'd1, 32'd0, 32'd4096, 32'h8000_0000, 32'd12};
    tb_list = '{32'd1024, 32'd64, 32'd0, 32'd2047, 32'd16, 32'd300};
    cur_bs = BLOCK_SIZE_RST;
    idle_pct = 28;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset layout: block size 256, 1024 blocks
    transfer(mk_alloc(32'd1, 32'd1));
    transfer(mk_alloc(32'd256, 32'd256));
    transfer(mk_alloc(32'd0, 32'd256));             // zero size
    transfer(mk_alloc(32'd100, 32'd0));             // zero alignment
    transfer(mk_alloc(32'd100, 32'd3));             // incompatible alignment
    transfer(mk_alloc(32'd100, 32'd1024));          // aligned split
    transfer(mk_alloc(32'hFFFF_FFFF, 32'd256));     // far too large
    transfer(mk_alloc(32'd1000, 32'h8000_0000));    // padding too large
    transfer(mk_alloc(32'hFFFF_FF00, 32'hFFFF_FFFF));
    transfer(mk_free(32'd2));
    transfer(mk_free(32'd0));                       // handle never issued
    transfer(mk_free(32'hFFFF_FFFF));
    transfer(mk_free(32'd1));
    transfer(mk_free(32'd3));
    transfer(mk_alloc(32'd262144, 32'd128));        // whole pool
    transfer(mk_alloc(32'd1, 32'd1));               // pool empty
    transfer(mk_free(32'd4));
    transfer(mk_free(32'd4));                       // already released

    // fill the handle table with one-block allocations, then one more
    write_reg(CFG_BLOCK_SIZE, 32'd1);
    repeat (1025) transfer(mk_alloc(32'd1, 32'd1));
    transfer(mk_free(32'hDEAD_BEEF));

    // random part: one setting per phase, idling rate by progress
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_BLOCK_SIZE, bs_list[p]);
      write_reg(CFG_TOTAL_BLOCKS, tb_list[p]);
      for (int n = 0; n < 125; n++) begin
        idle_pct = (p < 2) ? 28 : (p < 4) ? 83 : 0;
        // let the block drain completely midway through each phase
        if (n == 60) go_quiet();
        transfer(random_item());
      end
    end

    go_quiet();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
